[sv/fqr_pkg.sv]
package fqr_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int DATA_W    = 32;
  localparam int POS_W     = 4;
  localparam int OP_W      = 2;
  localparam int STAT_W    = 2;

  typedef enum logic [OP_W-1:0] {
    OP_ENQ   = 2'd0,
    OP_DEQ   = 2'd1,
    OP_DISC  = 2'd2,
    OP_QUERY = 2'd3
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  // Per-cell update control: load takes the request value, shift takes the
  // right-hand neighbor's value.
  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctl_t;

endpackage

[sv/fqr_cell.sv]
module fqr_cell
  import fqr_pkg::*;
(
  input  logic                     clk,
  input  cell_ctl_t                ctl,
  input  logic signed [DATA_W-1:0] load_value,
  input  logic signed [DATA_W-1:0] right_value,
  output logic signed [DATA_W-1:0] value,
  output logic signed [DATA_W-1:0] value_nxt
);

  logic signed [DATA_W-1:0] value_r;

  always_comb begin
    priority if (ctl.shift) begin
      value_nxt = right_value;
    end else if (ctl.load) begin
      value_nxt = load_value;
    end else begin
      value_nxt = value_r;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign value = value_r;

endmodule

[sv/fqr_ctrl.sv]
module fqr_ctrl
  import fqr_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  parameter int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  logic [OP_W-1:0]  operation,
  input  logic [POS_W-1:0] position,
  output logic [CNT_W-1:0] count_nxt,
  output status_t          status,
  output cell_ctl_t        cell_ctl [DEPTH]
);

  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  logic [CNT_W-1:0] count_r;
  logic [CMP_W-1:0] cnt_x;
  logic [CMP_W-1:0] rm_pos;
  op_t              op;
  logic             enq_ok;
  logic             rm_ok;

  assign op    = op_t'(operation);
  assign cnt_x = CMP_W'(count_r);

  always_comb begin
    enq_ok = 1'b0;
    rm_ok  = 1'b0;
    rm_pos = '0;
    status = ST_OK;
    unique case (op)
      OP_ENQ: begin
        if (cnt_x == CMP_W'(DEPTH)) begin
          status = ST_FULL;
        end else begin
          enq_ok = 1'b1;
        end
      end
      OP_DEQ: begin
        if (count_r == '0) begin
          status = ST_EMPTY;
        end else begin
          rm_ok = 1'b1;
        end
      end
      OP_DISC: begin
        rm_pos = CMP_W'(position);
        priority if (count_r == '0) begin
          status = ST_EMPTY;
        end else if (rm_pos >= cnt_x) begin
          status = ST_RANGE;
        end else begin
          rm_ok = 1'b1;
        end
      end
      OP_QUERY: begin
        status = ST_OK;
      end
      default: begin
        status = ST_OK;
      end
    endcase
  end

  always_comb begin
    priority if (accept && enq_ok) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (accept && rm_ok) begin
      count_nxt = count_r - CNT_W'(1);
    end else begin
      count_nxt = count_r;
    end
  end

  // Every cell at or after the removed slot pulls from its neighbor; the new
  // tail cell loads on an enqueue.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      cell_ctl[i].shift = accept && rm_ok && (CMP_W'(i) >= rm_pos);
      cell_ctl[i].load  = accept && enq_ok && (CMP_W'(i) == cnt_x);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

endmodule

[sv/fifo_queue_with_positional_remove.sv]
// Channel | Handshake          | Payload
// in      | in_valid/in_ready  | in_operation, in_value, in_position
// out     | out_valid/out_ready| out_head_value, out_head_valid, out_entry_count,
//         |                    | out_status
//
// Each request is applied to the cell chain in the cycle it is accepted,
// and its result appears registered on the next cycle: one request per cycle unless stalled.
// The single output register is refilled in the same cycle it is drained.
// Reset empties the queue and the output register; cell contents are not reset.
// While a result waits on out_ready, no new request is taken.
module fifo_queue_with_positional_remove
  import fqr_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  parameter int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [OP_W-1:0]          in_operation,
  input  logic signed [DATA_W-1:0] in_value,
  input  logic [POS_W-1:0]         in_position,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] out_head_value,
  output logic                     out_head_valid,
  output logic [CNT_W-1:0]         out_entry_count,
  output logic [STAT_W-1:0]        out_status
);

  logic                     accept;
  logic [CNT_W-1:0]         count_nxt;
  status_t                  status;
  cell_ctl_t                cell_ctl [DEPTH];
  logic signed [DATA_W-1:0] cell_value [DEPTH];
  logic signed [DATA_W-1:0] cell_value_nxt [DEPTH];

  logic                     out_valid_r;
  logic signed [DATA_W-1:0] out_head_value_r;
  logic                     out_head_valid_r;
  logic [CNT_W-1:0]         out_entry_count_r;
  logic [STAT_W-1:0]        out_status_r;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  fqr_ctrl #(
    .DEPTH (DEPTH),
    .CNT_W (CNT_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .operation (in_operation),
    .position  (in_position),
    .count_nxt (count_nxt),
    .status    (status),
    .cell_ctl  (cell_ctl)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [DATA_W-1:0] right_value;
    if (i == DEPTH - 1) begin : g_last
      assign right_value = cell_value[i];
    end else begin : g_mid
      assign right_value = cell_value[i+1];
    end

    fqr_cell u_cell (
      .clk         (clk),
      .ctl         (cell_ctl[i]),
      .load_value  (in_value),
      .right_value (right_value),
      .value       (cell_value[i]),
      .value_nxt   (cell_value_nxt[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_head_valid_r  <= (count_nxt != '0);
      out_head_value_r  <= (count_nxt != '0) ? cell_value_nxt[0] : '0;
      out_entry_count_r <= count_nxt;
      out_status_r      <= status;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_head_value  = out_head_value_r;
  assign out_head_valid  = out_head_valid_r;
  assign out_entry_count = out_entry_count_r;
  assign out_status      = out_status_r;

endmodule

[sv/fqr_checker.sv]
module fqr_checker
  import fqr_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  parameter int CNT_W = $clog2(DEPTH + 1)
) (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic signed [DATA_W-1:0] out_head_value,
  input logic                     out_head_valid,
  input logic [CNT_W-1:0]         out_entry_count,
  input logic [STAT_W-1:0]        out_status
);

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_head_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_head_valid == (out_entry_count != '0))
      && (out_head_valid || (out_head_value == '0))))
    else $error("head fields disagree with entry count");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_FULL)) |-> (out_entry_count == CNT_W'(DEPTH)))
    else $error("full status with queue not full");

  a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> out_valid)
    else $error("accepted request produced no result");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> (!in_ready ##1 (out_valid && $stable(out_entry_count)
      && $stable(out_status) && $stable(out_head_value))))
    else $error("stalled result changed or request taken");

endmodule

bind fifo_queue_with_positional_remove fqr_checker #(
  .DEPTH (DEPTH),
  .CNT_W (CNT_W)
) u_fqr_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_head_value  (out_head_value),
  .out_head_valid  (out_head_valid),
  .out_entry_count (out_entry_count),
  .out_status      (out_status)
);

[tb/testbench.sv]
module testbench
  import fqr_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CNT_W         = $clog2(DEPTH_DEF + 1);
  localparam int RANDOM_ITEMS  = 500;
  localparam int LONG_HOLD     = 300;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int IDLE_PERCENT  = 18;

  typedef struct packed {
    logic signed [DATA_W-1:0] head_value;
    logic                     head_valid;
    logic [CNT_W-1:0]         entry_count;
    status_t                  status;
  } queue_result_t;

  typedef struct packed {
    op_t                      op;
    logic signed [DATA_W-1:0] value;
    logic [POS_W-1:0]         position;
    logic                     typed;
    queue_result_t            want;
  } stim_row_t;

  localparam logic signed [DATA_W-1:0] MAX_POS = 32'sh7fffffff;
  localparam logic signed [DATA_W-1:0] MIN_NEG = 32'sh80000000;
  localparam queue_result_t NO_RESULT = '{32'sd0, 1'b0, '0, ST_OK};

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [OP_W-1:0]          in_operation = OP_QUERY;
  logic signed [DATA_W-1:0] in_value = '0;
  logic [POS_W-1:0]         in_position = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [DATA_W-1:0] out_head_value;
  logic                     out_head_valid;
  logic [CNT_W-1:0]         out_entry_count;
  logic [STAT_W-1:0]        out_status;

  // Typed expectation that travels with the request on the wire.
  logic                     req_typed = 1'b0;
  queue_result_t            req_want = NO_RESULT;

  logic                     steady = 1'b0;
  logic                     hold_req = 1'b0;
  bit                       hold_taken = 1'b0;
  int                       hold_left = 0;

  logic signed [DATA_W-1:0] model_entries[$];
  queue_result_t            expected_results[$];
  stim_row_t                directed_rows[$];
  int                       mismatch_count = 0;

  fifo_queue_with_positional_remove #(.DEPTH(DEPTH_DEF)) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_operation    (in_operation),
    .in_value        (in_value),
    .in_position     (in_position),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_head_value  (out_head_value),
    .out_head_valid  (out_head_valid),
    .out_entry_count (out_entry_count),
    .out_status      (out_status)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string field, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
    $display("%0t: %s mismatch, got 0x%0h, expected 0x%0h", $time, field, got, want);
    mismatch_count++;
  endtask

  // Applies one request to the shadow queue and returns the result it causes.
  function automatic queue_result_t predict_result(input logic [OP_W-1:0] op_bits,
                                                   input logic signed [DATA_W-1:0] value,
                                                   input logic [POS_W-1:0] position);
    queue_result_t r;
    r.status = ST_OK;
    case (op_t'(op_bits))
      OP_ENQ: begin
        if (model_entries.size() >= DEPTH_DEF) r.status = ST_FULL;
        else model_entries.push_back(value);
      end
      OP_DEQ: begin
        if (model_entries.size() == 0) r.status = ST_EMPTY;
        else void'(model_entries.pop_front());
      end
      OP_DISC: begin
        if (model_entries.size() == 0) r.status = ST_EMPTY;
        else if (position >= model_entries.size()) r.status = ST_RANGE;
        else model_entries.delete(position);
      end
      default: begin
      end
    endcase
    r.head_valid  = (model_entries.size() != 0);
    r.head_value  = r.head_valid ? model_entries[0] : '0;
    r.entry_count = CNT_W'(model_entries.size());
    return r;
  endfunction

  function automatic void add_row(input op_t op, input logic signed [DATA_W-1:0] value,
                                  input logic [POS_W-1:0] position, input logic typed,
                                  input queue_result_t want);
    directed_rows.push_back('{op, value, position, typed, want});
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(15))
      0: return MAX_POS;
      1: return MIN_NEG;
      2: return '0;
      3: return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_req(input op_t op, input logic signed [DATA_W-1:0] value,
                          input logic [POS_W-1:0] position, input logic typed,
                          input queue_result_t want);
    while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_value     <= value;
    in_position  <= position;
    req_typed    <= typed;
    req_want     <= want;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  // Scoreboard: results are checked before the request accepted at the same
  // edge is predicted, since a result is registered and always trails its request.
  always @(posedge clk) begin
    queue_result_t got, want, predicted;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_head_value, out_head_valid, out_entry_count, status_t'(out_status)};
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", DATA_W'(got.entry_count), '0);
      end else begin
        want = expected_results.pop_front();
        if (got.head_value !== want.head_value)
          report_mismatch("head_value", got.head_value, want.head_value);
        if (got.head_valid !== want.head_valid)
          report_mismatch("head_valid", DATA_W'(got.head_valid), DATA_W'(want.head_valid));
        if (got.entry_count !== want.entry_count)
          report_mismatch("entry_count", DATA_W'(got.entry_count), DATA_W'(want.entry_count));
        if (got.status !== want.status)
          report_mismatch("status", DATA_W'(got.status), DATA_W'(want.status));
      end
    end
    if (rst_n && in_valid && in_ready) begin
      predicted = predict_result(in_operation, in_value, in_position);
      expected_results.push_back(req_typed ? req_want : predicted);
    end
  end

  // Receiver: random stalls, one long hold-off when asked, none while steady.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (steady) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= IDLE_PERCENT);
      end
    end
  end

  initial begin
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[fifo_queue_with_positional_remove] ERROR");
    $finish;
  end

  initial begin
    int        fill_bias;
    int        enq_weight;
    int        roll;
    op_t       op;
    stim_row_t row;

    add_row(OP_QUERY, 32'sd0, 4'd0, 1'b1, '{32'sd0, 1'b0, 5'd0, ST_OK});
    add_row(OP_DEQ, 32'sh1234, 4'd0, 1'b1, '{32'sd0, 1'b0, 5'd0, ST_EMPTY});
    add_row(OP_DISC, -32'sd1, 4'd0, 1'b1, '{32'sd0, 1'b0, 5'd0, ST_EMPTY});
    add_row(OP_DISC, 32'sd0, 4'd15, 1'b1, '{32'sd0, 1'b0, 5'd0, ST_EMPTY});
    add_row(OP_ENQ, MAX_POS, 4'd15, 1'b1, '{MAX_POS, 1'b1, 5'd1, ST_OK});
    add_row(OP_DISC, 32'sd0, 4'd1, 1'b1, '{MAX_POS, 1'b1, 5'd1, ST_RANGE});
    // Discard at the head removes the last entry; the next enqueue lands at the head.
    add_row(OP_DISC, 32'sd0, 4'd0, 1'b1, '{32'sd0, 1'b0, 5'd0, ST_OK});
    add_row(OP_ENQ, MIN_NEG, 4'd0, 1'b1, '{MIN_NEG, 1'b1, 5'd1, ST_OK});
    for (int i = 1; i < DEPTH_DEF; i++) begin
      case (i)
        1: add_row(OP_ENQ, -32'sd1, POS_W'($urandom_range(15)), 1'b0, NO_RESULT);
        2: add_row(OP_ENQ, 32'sd0, POS_W'($urandom_range(15)), 1'b0, NO_RESULT);
        3: add_row(OP_ENQ, 32'sh55555555, 4'd0, 1'b0, NO_RESULT);
        4: add_row(OP_ENQ, 32'shaaaaaaaa, 4'd15, 1'b0, NO_RESULT);
        default: add_row(OP_ENQ, $urandom, POS_W'($urandom_range(15)), 1'b0, NO_RESULT);
      endcase
    end
    add_row(OP_ENQ, 32'sd7, 4'd0, 1'b1, '{MIN_NEG, 1'b1, 5'd16, ST_FULL});
    add_row(OP_DISC, 32'sd0, 4'd15, 1'b1, '{MIN_NEG, 1'b1, 5'd15, ST_OK});
    add_row(OP_DISC, 32'sd0, 4'd15, 1'b1, '{MIN_NEG, 1'b1, 5'd15, ST_RANGE});
    add_row(OP_DISC, 32'sd0, 4'd7, 1'b0, NO_RESULT);
    add_row(OP_DEQ, 32'sd0, 4'd0, 1'b0, NO_RESULT);
    add_row(OP_QUERY, 32'sd0, 4'd0, 1'b0, NO_RESULT);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      send_req(row.op, row.value, row.position, row.typed, row.want);
    end

    fill_bias = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // Alternate fill-heavy, drain-heavy and balanced stretches so the queue
      // keeps running into both full and empty.
      if (n % 40 == 0) fill_bias = $urandom_range(2);
      if (n == 100) hold_req <= 1'b1;
      if (n == 200) steady <= 1'b1;
      if (n == 300) steady <= 1'b0;
      if (n == 350) drain_results();
      enq_weight = (fill_bias == 0) ? 70 : (fill_bias == 1) ? 20 : 45;
      roll = $urandom_range(99);
      if (roll < enq_weight) begin
        op = OP_ENQ;
      end else begin
        case ($urandom_range(3))
          0: op = OP_DEQ;
          3: op = OP_QUERY;
          default: op = OP_DISC;
        endcase
      end
      send_req(op, pick_value(),
               ($urandom_range(1) != 0) ? POS_W'($urandom_range(7)) :
                                          POS_W'($urandom_range(15)),
               1'b0, NO_RESULT);
    end

    drain_results();
    repeat (4) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("[fifo_queue_with_positional_remove] OK");
    end else begin
      $display("[fifo_queue_with_positional_remove] ERROR");
    end
    $finish;
  end

endmodule

[fifo_queue_with_positional_remove.f]
sv/fqr_pkg.sv
sv/fqr_cell.sv
sv/fqr_ctrl.sv
sv/fifo_queue_with_positional_remove.sv
sv/fqr_checker.sv
tb/testbench.sv
